// ===== src/qslerp_pkg.sv =====
// ----------------------------------------------------------------------------
// qslerp_pkg: shared constants for the quaternion slerp pipeline
// Default widths, the threshold reset value and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package qslerp_pkg;

	localparam int COMPONENT_BITS_DEF = 16;
	localparam int CORDIC_STEPS_DEF   = 16;
	localparam int ANG_BITS           = 30;       // angle fraction bits
	localparam int W_ONE              = 65536;    // weight 1.0 in Q.16
	localparam logic [14:0] THR_RESET = 15'd32765;

	// atan(2^-i) in Q.30 radians, rounded
	function automatic logic [31:0] atan_q30(input int unsigned i);
		logic [31:0] v;
		case (i)
			0:       v = 32'd843314857;
			1:       v = 32'd497837829;
			2:       v = 32'd263043837;
			3:       v = 32'd133525159;
			4:       v = 32'd67021687;
			5:       v = 32'd33543516;
			6:       v = 32'd16775851;
			7:       v = 32'd8388437;
			8:       v = 32'd4194283;
			9:       v = 32'd2097149;
			default: v = (i <= 30) ? (32'd1 << (30 - i)) : 32'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== src/quaternion_slerp.sv =====
// ----------------------------------------------------------------------------
// quaternion_slerp: shortest-path spherical interpolation of two quaternions
//
// Requests arrive on the s_axis channel: two quaternions (signed Q1.F, F =
// COMPONENT_BITS-1) and a blend weight t (unsigned Q1.16). Each request gives
// exactly one result on m_axis, in order. The lerp threshold is written on
// the cfg channel (always ready); the user must write it only while the
// pipeline is empty, which the block itself does not enforce.
// Throughput: one request per cycle, back to back, while m_axis is not
// stalled. Every stage is a plain register stage; the sqrt runs one root
// bit per stage, each CORDIC runs one micro-rotation per stage and the
// weight divide one quotient bit per stage.
// Stall: the whole pipeline advances on one enable. When the result register
// holds a request and m_axis_tready is low, every stage holds and
// s_axis_tready drops; nothing is lost or repeated.
// Reset: arst_n clears all valid bits and loads the threshold 32765 (0.99991).
// Weight 0 returns the first quaternion and weight >= 1 the second, unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_slerp #(
	parameter int COMPONENT_BITS = qslerp_pkg::COMPONENT_BITS_DEF,
	parameter int CORDIC_STEPS   = qslerp_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	// first_w, first_x, first_y, first_z, second_w, second_x, second_y,
	// second_z, blend (17 bits), zero pad
	input  wire logic [((8*COMPONENT_BITS+17+7)/8)*8-1:0] s_axis_tdata,
	input  wire logic s_axis_tvalid,
	output logic      s_axis_tready,
	// out_w, out_x, out_y, out_z, zero pad
	output logic [((4*COMPONENT_BITS+7)/8)*8-1:0] m_axis_tdata,
	output logic      m_axis_tvalid,
	input  wire logic m_axis_tready,
	// lerp_threshold (15 bits), zero pad
	input  wire logic [15:0] cfg_tdata,
	input  wire logic cfg_tvalid,
	output logic      cfg_tready
);

	localparam int P   = COMPONENT_BITS;
	localparam int F   = P - 1;
	localparam int CS  = CORDIC_STEPS;
	localparam int NS  = F + 1;             // sqrt stages, one root bit each
	localparam int ANG = qslerp_pkg::ANG_BITS;
	localparam int AW  = 34;                // CORDIC x/y/z width
	localparam int RW  = 2 * F + 3;         // sqrt remainder width
	localparam int DW  = 50;                // divider width
	localparam int KB  = 17;                // weight bits, Q.16 up to 1.0
	localparam int L   = F + 2 * CS + 26;   // total stages
	localparam int OW  = ((4 * P + 7) / 8) * 8;

	localparam logic [F:0] ONEF = {1'b1, {F{1'b0}}};
	localparam logic [KB-1:0] WONE = KB'(qslerp_pkg::W_ONE);
	localparam logic signed [17:0] WONE18 = 18'sd65536;
	localparam logic signed [P+19:0] MAXV = {21'b0, {F{1'b1}}};
	localparam logic signed [P+19:0] MINV = {{21{1'b1}}, {F{1'b0}}};

	typedef struct packed {
		logic [3:0][P-1:0] a;
		logic [3:0][P-1:0] b;
		logic [16:0]       t;
		logic              pass1;  // t == 0
		logic              pass2;  // t >= 1.0
		logic              neg;    // second quaternion negated
		logic              lin;    // cosine above threshold
	} side_t;

	// ---------------- control ----------------
	logic [L-1:0] vld_s;
	logic         en;
	logic [14:0]  thr_q;

	assign en            = !vld_s[L-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_s[L-1];
	assign cfg_tready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			thr_q <= qslerp_pkg::THR_RESET;
		end else begin
			if (en)
				vld_s <= {vld_s[L-2:0], s_axis_tvalid};
			if (cfg_tvalid)
				thr_q <= cfg_tdata[14:0];
		end
	end

	// threshold scaled to F fraction bits
	logic [F-1:0] thr;
	if (F >= 15) begin : g_thr_up
		assign thr = F'(thr_q) << (F - 15);
	end else begin : g_thr_dn
		assign thr = F'(thr_q >> (15 - F));
	end

	// ---------------- s1: input register ----------------
	side_t side_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				side_s1.a[j] <= s_axis_tdata[j*P +: P];
				side_s1.b[j] <= s_axis_tdata[(4+j)*P +: P];
			end
			side_s1.t     <= s_axis_tdata[8*P +: 17];
			side_s1.pass1 <= (s_axis_tdata[8*P +: 17] == 17'd0);
			side_s1.pass2 <= s_axis_tdata[8*P+16];
			side_s1.neg   <= 1'b0;
			side_s1.lin   <= 1'b0;
		end
	end

	// ---------------- s2: component products ----------------
	side_t side_s2;
	logic signed [2*P-1:0] p_s2 [4];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++)
				p_s2[j] <= $signed(side_s1.a[j]) * $signed(side_s1.b[j]);
			side_s2 <= side_s1;
		end
	end

	// ---------------- s3: cosine, shortest path, threshold ----------------
	logic signed [2*P+1:0] dsum;
	logic signed [P+2:0]   dcos, cabs;
	logic                  negc;
	logic [F:0]            cclamp;
	side_t                 side_c3;
	side_t side_s3;
	logic [F:0] c_s3;

	always_comb begin
		dsum = '0;
		for (int j = 0; j < 4; j++)
			dsum = dsum + (2*P+2)'(p_s2[j]);
		dcos   = (P+3)'(dsum >>> F);       // exact floor of sum / 2^F
		negc   = dcos < 0;
		cabs   = negc ? -dcos : dcos;
		cclamp = (cabs > (P+3)'(ONEF)) ? ONEF : cabs[F:0];
		side_c3     = side_s2;
		side_c3.neg = negc;
		side_c3.lin = cclamp > (F+1)'(thr);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s3    <= cclamp;
			side_s3 <= side_c3;
		end
	end

	// ---------------- s4: cosine squared ----------------
	side_t side_s4;
	logic [F:0]     c_s4;
	logic [2*F+1:0] csq_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			csq_s4  <= c_s3 * c_s3;
			c_s4    <= c_s3;
			side_s4 <= side_s3;
		end
	end

	// ---------------- s5: sine = sqrt(1 - c^2), one bit per stage ----------------
	side_t          side_s5 [NS];
	logic [RW-1:0]  rem_s5  [NS];
	logic [F:0]     root_s5 [NS];
	logic [F:0]     c_s5    [NS];

	for (genvar i = 0; i < NS; i++) begin : g_sqrt
		localparam int K = F - i;
		logic [RW-1:0] rem_in, trial;
		logic [F:0]    root_in, c_in;
		side_t         sd_in;
		if (i == 0) begin : g_first
			assign rem_in  = (RW'(1) << (2 * F)) - RW'(csq_s4);
			assign root_in = '0;
			assign c_in    = c_s4;
			assign sd_in   = side_s4;
		end else begin : g_next
			assign rem_in  = rem_s5[i-1];
			assign root_in = root_s5[i-1];
			assign c_in    = c_s5[i-1];
			assign sd_in   = side_s5[i-1];
		end
		// (R + 2^K)^2 - R^2
		assign trial = (RW'(root_in) << (K + 1)) + (RW'(1) << (2 * K));
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_s5[i]  <= rem_in - trial;
					root_s5[i] <= root_in | ((F+1)'(1) << K);
				end else begin
					rem_s5[i]  <= rem_in;
					root_s5[i] <= root_in;
				end
				c_s5[i]    <= c_in;
				side_s5[i] <= sd_in;
			end
		end
	end

	// ---------------- s6: CORDIC vectoring, theta = atan2(s, c) ----------------
	logic signed [AW-1:0] cq30, sq30;
	if (F <= ANG) begin : g_q30_up
		assign cq30 = AW'(c_s5[NS-1]) << (ANG - F);
		assign sq30 = AW'(root_s5[NS-1]) << (ANG - F);
	end else begin : g_q30_dn
		assign cq30 = AW'(c_s5[NS-1] >> (F - ANG));
		assign sq30 = AW'(root_s5[NS-1] >> (F - ANG));
	end

	side_t                side_s6 [CS];
	logic signed [AW-1:0] vx_s6 [CS];
	logic signed [AW-1:0] vy_s6 [CS];
	logic signed [AW-1:0] vz_s6 [CS];

	for (genvar i = 0; i < CS; i++) begin : g_vec
		logic signed [AW-1:0] x_in, y_in, z_in, dx, dy, at;
		side_t                sd_in;
		if (i == 0) begin : g_first
			assign x_in  = cq30;
			assign y_in  = sq30;
			assign z_in  = '0;
			assign sd_in = side_s5[NS-1];
		end else begin : g_next
			assign x_in  = vx_s6[i-1];
			assign y_in  = vy_s6[i-1];
			assign z_in  = vz_s6[i-1];
			assign sd_in = side_s6[i-1];
		end
		assign dx = y_in >>> i;
		assign dy = x_in >>> i;
		assign at = AW'(qslerp_pkg::atan_q30(i));
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_in > 0) begin
					vx_s6[i] <= x_in + dx;
					vy_s6[i] <= y_in - dy;
					vz_s6[i] <= z_in + at;
				end else begin
					vx_s6[i] <= x_in - dx;
					vy_s6[i] <= y_in + dy;
					vz_s6[i] <= z_in - at;
				end
				side_s6[i] <= sd_in;
			end
		end
	end

	// ---------------- s7: partial angles (1-t)theta, t*theta ----------------
	logic signed [17:0]    wt, wr;
	logic signed [AW+17:0] m1, m2;
	side_t                 side_s7;
	logic signed [AW-1:0]  ang_s7 [3];

	assign wt = $signed({1'b0, side_s6[CS-1].t});
	assign wr = WONE18 - wt;
	assign m1 = vz_s6[CS-1] * wr;
	assign m2 = vz_s6[CS-1] * wt;

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s7[0] <= vz_s6[CS-1];
			ang_s7[1] <= AW'(m1 >>> 16);
			ang_s7[2] <= AW'(m2 >>> 16);
			side_s7   <= side_s6[CS-1];
		end
	end

	// ---------------- s8: three CORDIC rotations, sine of each angle ----------------
	// lane 0: sin(theta), lane 1: sin((1-t)theta), lane 2: sin(t theta); gain cancels
	side_t                side_s8 [CS];
	logic signed [AW-1:0] rx_s8 [CS][3];
	logic signed [AW-1:0] ry_s8 [CS][3];
	logic signed [AW-1:0] rz_s8 [CS][3];

	for (genvar i = 0; i < CS; i++) begin : g_rot
		logic signed [AW-1:0] x_in [3];
		logic signed [AW-1:0] y_in [3];
		logic signed [AW-1:0] z_in [3];
		logic signed [AW-1:0] at;
		side_t                sd_in;
		for (genvar j = 0; j < 3; j++) begin : g_lane
			if (i == 0) begin : g_first
				assign x_in[j] = AW'(1) << ANG;
				assign y_in[j] = '0;
				assign z_in[j] = ang_s7[j];
			end else begin : g_next
				assign x_in[j] = rx_s8[i-1][j];
				assign y_in[j] = ry_s8[i-1][j];
				assign z_in[j] = rz_s8[i-1][j];
			end
		end
		if (i == 0) begin : g_sd_first
			assign sd_in = side_s7;
		end else begin : g_sd_next
			assign sd_in = side_s8[i-1];
		end
		assign at = AW'(qslerp_pkg::atan_q30(i));
		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < 3; j++) begin
					if (z_in[j] >= 0) begin
						rx_s8[i][j] <= x_in[j] - (y_in[j] >>> i);
						ry_s8[i][j] <= y_in[j] + (x_in[j] >>> i);
						rz_s8[i][j] <= z_in[j] - at;
					end else begin
						rx_s8[i][j] <= x_in[j] + (y_in[j] >>> i);
						ry_s8[i][j] <= y_in[j] - (x_in[j] >>> i);
						rz_s8[i][j] <= z_in[j] + at;
					end
				end
				side_s8[i] <= sd_in;
			end
		end
	end

	// ---------------- s9: divider setup ----------------
	logic signed [AW-1:0] gsin;
	side_t                side_s9;
	logic [DW-1:0]        gs_s9;
	logic                 deg_s9;
	logic [DW-1:0]        rem_s9  [2];
	logic                 zero_s9 [2];
	logic                 sat_s9  [2];

	assign gsin = ry_s8[CS-1][0];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 2; j++) begin
				rem_s9[j]  <= DW'(ry_s8[CS-1][j+1]) << 16;
				zero_s9[j] <= ry_s8[CS-1][j+1] <= 0;
				// quotient would reach 2.0: saturates to 1.0 anyway
				sat_s9[j]  <= (AW+1)'(ry_s8[CS-1][j+1]) >= ((AW+1)'(gsin) <<< 1);
			end
			gs_s9   <= DW'(gsin);
			deg_s9  <= gsin <= 0;
			side_s9 <= side_s8[CS-1];
		end
	end

	// ---------------- s10: restoring divide, one quotient bit per stage ----------------
	side_t         side_s10 [KB];
	logic [DW-1:0] gs_s10   [KB];
	logic          deg_s10  [KB];
	logic [DW-1:0] rem_s10  [KB][2];
	logic [KB-1:0] q_s10    [KB][2];
	logic          zero_s10 [KB][2];
	logic          sat_s10  [KB][2];

	for (genvar i = 0; i < KB; i++) begin : g_div
		localparam int K = KB - 1 - i;
		logic [DW-1:0] gs_in, dv;
		logic          deg_in;
		side_t         sd_in;
		logic [DW-1:0] rem_in  [2];
		logic [KB-1:0] q_in    [2];
		logic          zero_in [2];
		logic          sat_in  [2];
		if (i == 0) begin : g_first
			assign gs_in  = gs_s9;
			assign deg_in = deg_s9;
			assign sd_in  = side_s9;
			for (genvar j = 0; j < 2; j++) begin : g_lane
				assign rem_in[j]  = rem_s9[j];
				assign q_in[j]    = '0;
				assign zero_in[j] = zero_s9[j];
				assign sat_in[j]  = sat_s9[j];
			end
		end else begin : g_next
			assign gs_in  = gs_s10[i-1];
			assign deg_in = deg_s10[i-1];
			assign sd_in  = side_s10[i-1];
			for (genvar j = 0; j < 2; j++) begin : g_lane
				assign rem_in[j]  = rem_s10[i-1][j];
				assign q_in[j]    = q_s10[i-1][j];
				assign zero_in[j] = zero_s10[i-1][j];
				assign sat_in[j]  = sat_s10[i-1][j];
			end
		end
		assign dv = gs_in << K;
		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < 2; j++) begin
					if (rem_in[j] >= dv) begin
						rem_s10[i][j] <= rem_in[j] - dv;
						q_s10[i][j]   <= q_in[j] | (KB'(1) << K);
					end else begin
						rem_s10[i][j] <= rem_in[j];
						q_s10[i][j]   <= q_in[j];
					end
					zero_s10[i][j] <= zero_in[j];
					sat_s10[i][j]  <= sat_in[j];
				end
				gs_s10[i]   <= gs_in;
				deg_s10[i]  <= deg_in;
				side_s10[i] <= sd_in;
			end
		end
	end

	// ---------------- s11: weight select and weighted products ----------------
	side_t              sd_w;
	logic [KB-1:0]      kq [2];
	logic               lin_all;
	logic signed [17:0] k1, k2, tw;

	assign sd_w    = side_s10[KB-1];
	assign lin_all = sd_w.lin || deg_s10[KB-1];
	assign tw      = $signed({1'b0, sd_w.t});

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			if (zero_s10[KB-1][j])
				kq[j] = '0;
			else if (sat_s10[KB-1][j] || (q_s10[KB-1][j] > WONE))
				kq[j] = WONE;
			else
				kq[j] = q_s10[KB-1][j];
		end
		if (lin_all) begin
			k1 = WONE18 - tw;
			k2 = tw;
		end else begin
			k1 = $signed({1'b0, kq[0]});
			k2 = $signed({1'b0, kq[1]});
		end
	end

	side_t                side_s11;
	logic signed [P+17:0] pa_s11 [4];
	logic signed [P+18:0] pb_s11 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				pa_s11[j] <= k1 * $signed(sd_w.a[j]);
				if (sd_w.neg)
					pb_s11[j] <= k2 * (-((P+1)'($signed(sd_w.b[j]))));
				else
					pb_s11[j] <= k2 * (P+1)'($signed(sd_w.b[j]));
			end
			side_s11 <= sd_w;
		end
	end

	// ---------------- s12: round, saturate, pass-through, result register ----------------
	logic signed [P+19:0] acc [4];
	logic signed [P+19:0] shv [4];
	logic [3:0][P-1:0]    res_c;
	logic [4*P-1:0]       res_s12;

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			acc[j] = (P+20)'(pa_s11[j]) + (P+20)'(pb_s11[j]) + (P+20)'(32768);
			shv[j] = acc[j] >>> 16;
			if (side_s11.pass1)
				res_c[j] = side_s11.a[j];
			else if (side_s11.pass2)
				res_c[j] = side_s11.b[j];
			else if (shv[j] > MAXV)
				res_c[j] = MAXV[P-1:0];
			else if (shv[j] < MINV)
				res_c[j] = MINV[P-1:0];
			else
				res_c[j] = shv[j][P-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			res_s12 <= res_c;
	end

	assign m_axis_tdata = OW'(res_s12);

	// ---------------- assertions ----------------
	a_cos_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[2] |-> (c_s3 <= ONEF))
		else $error("cosine above 1.0 after clamp");

	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[L-3] && !sd_w.pass2) |-> (k1 <= WONE18 && k2 <= WONE18 && k2 >= 0))
		else $error("interpolation weight out of range");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

// ===== bench/tb_quaternion_slerp.sv =====
// ----------------------------------------------------------------------------
// tb_quaternion_slerp: self-checking bench for the quaternion slerp pipeline
// Random and directed requests are driven in bursts and each result is
// checked against a bit-exact fixed-point predictor. The receiver stalls on
// its own pattern. The threshold is rewritten between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_quaternion_slerp;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 100;
	localparam int PHASE_ITEMS    = 420;

	// atan(2^-i) in Q.30 for the first ten steps; 2^(30-i) beyond
	localparam longint ATAN_LOW [10] = '{
		843314857, 497837829, 263043837, 133525159, 67021687,
		33543516, 16775851, 8388437, 4194283, 2097149
	};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic [151:0] s_axis_tdata = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [63:0]  m_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [15:0]  cfg_tdata = '0;
	logic         cfg_tvalid = 1'b0;
	logic         cfg_tready;

	logic [151:0] pending_reqs [$];   // requests waiting to be driven
	logic [63:0]  expected_quats [$]; // predicted results, oldest first
	logic [14:0]  threshold = qslerp_pkg::THR_RESET;
	int           errors = 0;

	always #4 clk = ~clk;

	quaternion_slerp DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cfg_tdata(cfg_tdata),
		.cfg_tvalid(cfg_tvalid),
		.cfg_tready(cfg_tready)
	);

	// ---------------------------------------------------------------- predictor
	function automatic longint atan_at(int i);
		if (i < 10) return ATAN_LOW[i];
		if (i <= 30) return longint'(1) << (30 - i);
		return 0;
	endfunction

	// vectoring: angle of (x, y), Q.30 radians
	function automatic longint cordic_angle(longint x, longint y);
		longint z, dx, dy;
		z = 0;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += atan_at(i);
			end else begin
				x -= dx; y += dy; z -= atan_at(i);
			end
		end
		return z;
	endfunction

	// rotation of (2^30, 0) by a; gain left in, it cancels in the ratio
	function automatic longint cordic_sin(longint a);
		longint x, y, dx, dy;
		x = longint'(1) << 30;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (a >= 0) begin
				x -= dx; y += dy; a -= atan_at(i);
			end else begin
				x += dx; y -= dy; a += atan_at(i);
			end
		end
		return y;
	endfunction

	function automatic longint weight_ratio(longint g, longint gs);
		longint k;
		k = (g * 65536) / gs;
		if (k < 0) k = 0;
		if (k > 65536) k = 65536;
		return k;
	endfunction

	function automatic longint int_sqrt(longint v);
		longint r, bit_v;
		r = 0;
		bit_v = longint'(1) << 62;
		while (bit_v > v) bit_v = bit_v >> 2;
		while (bit_v != 0) begin
			if (v >= r + bit_v) begin
				v -= r + bit_v;
				r = (r >> 1) + bit_v;
			end else begin
				r = r >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] slerp_predict(logic [151:0] req, logic [14:0] thr);
		longint qa [4], qb [4];
		longint t, p, h, hs, ls, c, k1, k2, s, theta, gs, v;
		logic [63:0] res;
		t = req[144:128];
		if (t == 0) return req[63:0];       // weight zero: first as is
		if (t >= 65536) return req[127:64]; // weight one or more: second as is
		hs = 0;
		ls = 0;
		for (int j = 0; j < 4; j++) begin
			qa[j] = $signed(req[16*j +: 16]);
			qb[j] = $signed(req[64 + 16*j +: 16]);
			p = qa[j] * qb[j];
			h = p >>> 15;
			hs += h;
			ls += p - h * 32768;
		end
		c = hs + (ls >>> 15);
		// shortest path: flip the second when the dot product is negative
		if (c < 0) begin
			for (int j = 0; j < 4; j++) qb[j] = -qb[j];
			c = -c;
		end
		if (c > 32768) c = 32768;   // non-unit inputs
		k1 = 65536 - t;
		k2 = t;
		if (c <= longint'(thr)) begin
			s = int_sqrt((longint'(1) << 30) - c * c);
			theta = cordic_angle(c << 15, s << 15);
			gs = cordic_sin(theta);
			if (gs > 0) begin   // degenerate sine keeps linear weights
				k1 = weight_ratio(cordic_sin((theta * (65536 - t)) >>> 16), gs);
				k2 = weight_ratio(cordic_sin((theta * t) >>> 16), gs);
			end
		end
		for (int j = 0; j < 4; j++) begin
			v = (k1 * qa[j] + k2 * qb[j] + 32768) >>> 16;
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
			res[16*j +: 16] = v[15:0];
		end
		return res;
	endfunction

	// ---------------------------------------------------------------- driver
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_quats.push_back(slerp_predict(s_axis_tdata, threshold));
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					s_axis_tdata  <= pending_reqs.pop_front();
					s_axis_tvalid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- receiver
	int stall_mode = 0;
	int mode_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left  = $urandom_range(20, 300);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// ---------------------------------------------------------------- monitor
	task automatic report_mismatch(string field, logic [15:0] want, logic [15:0] got);
		$display("mismatch %s: expected %0d got %0d", field,
			$signed(want), $signed(got));
		errors++;
	endtask

	string field_names [4] = '{"out_w", "out_x", "out_y", "out_z"};

	always @(posedge clk) begin
		logic [63:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_quats.size() == 0) begin
				$display("unexpected result %h", m_axis_tdata);
				errors++;
			end else begin
				want = expected_quats.pop_front();
				for (int j = 0; j < 4; j++)
					if (want[16*j +: 16] !== m_axis_tdata[16*j +: 16])
						report_mismatch(field_names[j], want[16*j +: 16],
							m_axis_tdata[16*j +: 16]);
			end
		end
	end

	// ---------------------------------------------------------------- watchdog
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus
	function automatic logic [151:0] pack_req(int qa [4], int qb [4], int t);
		logic [151:0] r;
		r = '0;
		for (int j = 0; j < 4; j++) begin
			r[16*j +: 16]      = qa[j][15:0];
			r[64 + 16*j +: 16] = qb[j][15:0];
		end
		r[144:128] = t[16:0];
		return r;
	endfunction

	function automatic int clamp16(int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	task automatic random_unit(output int q [4]);
		real r [4];
		real n;
		n = 0.0;
		for (int j = 0; j < 4; j++) begin
			r[j] = ($itor($urandom_range(0, 65535)) - 32768.0) / 32768.0;
			n += r[j] * r[j];
		end
		if (n < 1.0e-6) begin
			r[0] = 1.0;
			n = 1.0;
		end
		n = $sqrt(n);
		for (int j = 0; j < 4; j++) q[j] = clamp16($rtoi(r[j] / n * 32767.0));
	endtask

	function automatic int random_blend();
		case ($urandom_range(0, 19))
			0: return 0;
			1: return 65536;
			2: return $urandom_range(65537, 131071);
			3: return $urandom_range(1, 64);
			4: return $urandom_range(65472, 65535);
			default: return $urandom_range(1, 65535);
		endcase
	endfunction

	task automatic add_random(int count);
		int qa [4], qb [4];
		int k, sgn;
		for (int n = 0; n < count; n++) begin
			random_unit(qa);
			case ($urandom_range(0, 9))
				6, 7: begin   // nearly equal pair, often flipped: linear path
					k = $urandom_range(0, 64);
					sgn = $urandom_range(0, 1) ? -1 : 1;
					for (int j = 0; j < 4; j++)
						qb[j] = clamp16(sgn * (qa[j] + $urandom_range(0, 2*k) - k));
				end
				8: begin      // raw noise, non-unit
					for (int j = 0; j < 4; j++) begin
						qa[j] = $signed(16'($urandom));
						qb[j] = $signed(16'($urandom));
					end
				end
				default: random_unit(qb);
			endcase
			pending_reqs.push_back(pack_req(qa, qb, random_blend()));
		end
	endtask

	task automatic add_directed();
		int one [4]  = '{32767, 0, 0, 0};
		int neg [4]  = '{-32768, 0, 0, 0};
		int ox [4]   = '{0, 32767, 0, 0};
		int mx [4]   = '{32767, 32767, 32767, 32767};
		int mn [4]   = '{-32768, -32768, -32768, -32768};
		int zr [4]   = '{0, 0, 0, 0};
		int hf [4]   = '{23170, 23170, 0, 0};
		int hn [4]   = '{-23170, 0, 23170, 0};
		pending_reqs.push_back(pack_req(one, ox, 0));        // weight zero
		pending_reqs.push_back(pack_req(one, ox, 65536));    // weight one
		pending_reqs.push_back(pack_req(one, ox, 131071));   // above one
		pending_reqs.push_back(pack_req(one, ox, 32768));    // orthogonal
		pending_reqs.push_back(pack_req(one, ox, 1));
		pending_reqs.push_back(pack_req(one, ox, 65535));
		pending_reqs.push_back(pack_req(one, neg, 32768));   // opposite: flip
		pending_reqs.push_back(pack_req(one, one, 32768));   // identical
		pending_reqs.push_back(pack_req(mx, mn, 16384));     // non-unit, clamp
		pending_reqs.push_back(pack_req(mn, mn, 49152));
		pending_reqs.push_back(pack_req(mx, mx, 32768));
		pending_reqs.push_back(pack_req(zr, zr, 32768));
		pending_reqs.push_back(pack_req(zr, one, 32768));
		pending_reqs.push_back(pack_req(hf, hn, 20000));     // negative dot
		pending_reqs.push_back(pack_req(hf, one, 45000));
		pending_reqs.push_back(pack_req(hn, ox, 100));
		pending_reqs.push_back(pack_req(mn, ox, 65000));
		pending_reqs.push_back(pack_req(mx, zr, 131071));
		pending_reqs.push_back(pack_req(mn, mx, 0));
		pending_reqs.push_back(pack_req(neg, neg, 7));
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || s_axis_tvalid || expected_quats.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_threshold(logic [14:0] value);
		@(posedge clk);
		cfg_tdata  <= {1'b0, value};
		cfg_tvalid <= 1'b1;
		do @(posedge clk); while (!cfg_tready);
		cfg_tvalid <= 1'b0;
		threshold = value;
	endtask

	initial begin
		logic [14:0] settings [5];
		settings = '{15'd0, 15'd32767, 15'd16384, 15'd32000, 15'($urandom)};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// reset threshold first, then one phase per setting, then the reset threshold again
		add_directed();
		add_random(PHASE_ITEMS - 20);
		wait_drained();
		foreach (settings[i]) begin
			write_threshold(settings[i]);
			@(negedge clk);
			if (i == 0) add_directed();
			add_random((i == 0) ? PHASE_ITEMS - 20 : PHASE_ITEMS / 2);
			wait_drained();
		end
		write_threshold(qslerp_pkg::THR_RESET);
		@(negedge clk);
		add_random(PHASE_ITEMS / 2);
		wait_drained();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/qslerp_pkg.sv
src/quaternion_slerp.sv
bench/tb_quaternion_slerp.sv
